// ===== sv/msc_pkg.sv =====
// Shared types, constants and helper functions for the mark-sweep cell collector.
// This package has no dependencies. The sequencer and the top level import it; the RAM does not.
package msc_pkg;

    localparam int PAIR_CELLS  = 512;
    localparam int INT_CELLS   = 512;
    localparam int ROOT_SLOTS  = 8;
    localparam int STACK_DEPTH = 256;

    localparam int IDX_W   = 9;
    localparam int HEAD_W  = 10;
    localparam int CNT_W   = 9;
    localparam int SP_W    = 8;
    localparam int SLOT_W  = 3;
    localparam int CST_W   = 2;

    localparam logic [HEAD_W-1:0] HEAD_END  = HEAD_W'(PAIR_CELLS);
    localparam logic [IDX_W-1:0]  CELL_LAST = IDX_W'(PAIR_CELLS - 1);
    localparam logic [SLOT_W-1:0] ROOT_LAST = SLOT_W'(ROOT_SLOTS - 1);

    localparam logic [1:0] KIND_NULL = 2'd0;
    localparam logic [1:0] KIND_INT  = 2'd1;
    localparam logic [1:0] KIND_PAIR = 2'd2;

    localparam logic [CST_W-1:0] CS_FREE     = 2'd0;
    localparam logic [CST_W-1:0] CS_UNMARKED = 2'd1;
    localparam logic [CST_W-1:0] CS_MARKED   = 2'd2;

    localparam logic [2:0] OP_ALLOC_PAIR = 3'd0;
    localparam logic [2:0] OP_ALLOC_INT  = 3'd1;
    localparam logic [2:0] OP_WRITE_PAIR = 3'd2;
    localparam logic [2:0] OP_SET_ROOT   = 3'd3;
    localparam logic [2:0] OP_PUSH_LOCAL = 3'd4;
    localparam logic [2:0] OP_POP_LOCAL  = 3'd5;
    localparam logic [2:0] OP_COLLECT    = 3'd6;

    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_EMPTY     = 2'd1;
    localparam logic [1:0] STS_TRACE_OVF = 2'd2;
    localparam logic [1:0] STS_LOCAL_OVF = 2'd3;

    typedef struct packed {
        logic [1:0]       kind;
        logic [IDX_W-1:0] idx;
    } t_ref;

    localparam int REF_W = $bits(t_ref);

    typedef struct packed {
        logic [2:0] opcode;
        logic [8:0] cell_index;
        logic [2:0] root_slot;
        logic [1:0] car_kind;
        logic [8:0] car_index;
        logic [1:0] cdr_kind;
        logic [8:0] cdr_index;
    } t_in_req;

    typedef struct packed {
        logic [1:0] status;
        logic [1:0] ref_kind;
        logic [8:0] ref_index;
    } t_out_req;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_AP_WR, S_AI_WR, S_WP_WR, S_PU_WR, S_PO_ST, S_PO_WR,
        S_CR_RD, S_CR_EV, S_CL_RD, S_CL_ST, S_CL_EV, S_TR_POP, S_TR_RD,
        S_TR_KID, S_TR_ST, S_TR_EV, S_SW_RD, S_SW_WR, S_RESP
    } t_state;

    function automatic t_ref mk_ref(logic [1:0] kind, logic [IDX_W-1:0] idx);
        t_ref r;
        r = '0;
        if (kind == KIND_INT || kind == KIND_PAIR) begin
            r.kind = kind;
            r.idx  = idx;
        end
        return r;
    endfunction

    function automatic logic [CST_W-1:0] sel_state(t_ref r, logic [CST_W-1:0] pst,
                                                   logic [CST_W-1:0] ist);
        logic [CST_W-1:0] s;
        s = CS_FREE;
        if (r.kind == KIND_INT) begin
            s = ist;
        end else if (r.kind == KIND_PAIR) begin
            s = pst;
        end
        return s;
    endfunction

endpackage

// ===== sv/msc_ram.sv =====
// Simple dual-port RAM with one write port and one registered read port.
// Generic storage for the collector; it uses no package.
module msc_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== sv/msc_seq.sv =====
// Sequencer and datapath of the collector: request decode, free lists, locals,
// mark tracing and sweeping. It drives the cell memories held in the top level.
// Depends on msc_pkg.
module msc_seq (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  msc_pkg::t_in_req         i_in_req,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output msc_pkg::t_out_req        o_out_req,
    output logic                     o_car_we,
    output logic [8:0]               o_car_waddr,
    output msc_pkg::t_ref            o_car_wdata,
    output logic [8:0]               o_car_raddr,
    input  msc_pkg::t_ref            i_car_rdata,
    output logic                     o_cdr_we,
    output logic [8:0]               o_cdr_waddr,
    output msc_pkg::t_ref            o_cdr_wdata,
    output logic [8:0]               o_cdr_raddr,
    input  msc_pkg::t_ref            i_cdr_rdata,
    output logic                     o_pst_we,
    output logic [8:0]               o_pst_waddr,
    output logic [1:0]               o_pst_wdata,
    output logic [8:0]               o_pst_raddr,
    input  logic [1:0]               i_pst_rdata,
    output logic                     o_ist_we,
    output logic [8:0]               o_ist_waddr,
    output logic [1:0]               o_ist_wdata,
    output logic [8:0]               o_ist_raddr,
    input  logic [1:0]               i_ist_rdata,
    output logic                     o_lnk_we,
    output logic [8:0]               o_lnk_waddr,
    output logic [9:0]               o_lnk_wdata,
    output logic [8:0]               o_lnk_raddr,
    input  logic [9:0]               i_lnk_rdata,
    output logic                     o_loc_we,
    output logic [7:0]               o_loc_waddr,
    output msc_pkg::t_ref            o_loc_wdata,
    output logic [7:0]               o_loc_raddr,
    input  msc_pkg::t_ref            i_loc_rdata,
    output logic                     o_trc_we,
    output logic [7:0]               o_trc_waddr,
    output msc_pkg::t_ref            o_trc_wdata,
    output logic [7:0]               o_trc_raddr,
    input  msc_pkg::t_ref            i_trc_rdata
);
    import msc_pkg::*;

    t_state              r_state, n_state;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [HEAD_W-1:0]   r_phead, n_phead;
    logic [HEAD_W-1:0]   r_ihead, n_ihead;
    logic [CNT_W-1:0]    r_lcnt, n_lcnt;
    logic [CNT_W-1:0]    r_tcnt, n_tcnt;
    t_ref                r_roots [ROOT_SLOTS];
    t_ref                n_roots [ROOT_SLOTS];
    logic [IDX_W-1:0]    r_cell, n_cell;
    t_ref                r_car, n_car;
    t_ref                r_cdr, n_cdr;
    t_ref                r_ref, n_ref;
    t_ref                r_kid, n_kid;
    t_ref                r_res, n_res;
    logic [1:0]          r_status, n_status;
    logic                r_second, n_second;
    logic                r_abort, n_abort;
    logic                r_out_valid, n_out_valid;
    t_out_req            r_out, n_out;

    t_ref                in_car;
    t_ref                in_cdr;
    t_ref                root_cur;
    logic [CST_W-1:0]    cur_st;
    logic [CNT_W-1:0]    lcnt_dec;
    logic [CNT_W-1:0]    tcnt_dec;
    logic [CNT_W-1:0]    idx_inc;
    logic                st_we;
    logic [CST_W-1:0]    st_val;
    logic                push_go;
    logic                push_ovf;

    assign in_car   = mk_ref(i_in_req.car_kind, i_in_req.car_index);
    assign in_cdr   = mk_ref(i_in_req.cdr_kind, i_in_req.cdr_index);
    assign root_cur = r_roots[r_idx[SLOT_W-1:0]];
    assign cur_st   = sel_state(r_ref, i_pst_rdata, i_ist_rdata);
    assign lcnt_dec = r_lcnt - CNT_W'(1);
    assign tcnt_dec = r_tcnt - CNT_W'(1);
    assign idx_inc  = {1'b0, r_idx[IDX_W-2:0]} + CNT_W'(1);
    assign push_ovf = r_tcnt[CNT_W-1];

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_phead     = r_phead;
        n_ihead     = r_ihead;
        n_lcnt      = r_lcnt;
        n_tcnt      = r_tcnt;
        n_roots     = r_roots;
        n_cell      = r_cell;
        n_car       = r_car;
        n_cdr       = r_cdr;
        n_ref       = r_ref;
        n_kid       = r_kid;
        n_res       = r_res;
        n_status    = r_status;
        n_second    = r_second;
        n_abort     = r_abort;
        n_out_valid = r_out_valid & i_out_stall;
        n_out       = r_out;

        o_car_we = 1'b0; o_car_waddr = r_idx; o_car_wdata = '0; o_car_raddr = r_idx;
        o_cdr_we = 1'b0; o_cdr_waddr = r_idx; o_cdr_wdata = '0; o_cdr_raddr = r_idx;
        o_pst_we = 1'b0; o_pst_waddr = r_idx; o_pst_wdata = CS_FREE; o_pst_raddr = r_idx;
        o_ist_we = 1'b0; o_ist_waddr = r_idx; o_ist_wdata = CS_FREE; o_ist_raddr = r_idx;
        o_lnk_we = 1'b0; o_lnk_waddr = r_idx; o_lnk_wdata = '0; o_lnk_raddr = r_idx;
        o_loc_we = 1'b0; o_loc_waddr = r_lcnt[SP_W-1:0]; o_loc_wdata = r_car;
        o_loc_raddr = r_idx[SP_W-1:0];
        o_trc_we = 1'b0; o_trc_waddr = r_tcnt[SP_W-1:0]; o_trc_wdata = r_ref;
        o_trc_raddr = tcnt_dec[SP_W-1:0];

        st_we   = 1'b0;
        st_val  = CS_MARKED;
        push_go = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                o_car_we    = 1'b1;
                o_cdr_we    = 1'b1;
                o_cdr_wdata = (r_idx == '0) ? '0 : t_ref'({KIND_PAIR, r_idx - IDX_W'(1)});
                o_pst_we    = 1'b1;
                o_ist_we    = 1'b1;
                o_lnk_we    = 1'b1;
                o_lnk_wdata = (r_idx == '0) ? HEAD_END : {1'b0, r_idx - IDX_W'(1)};
                if (r_idx == CELL_LAST) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_IDLE: begin
                o_cdr_raddr = r_phead[IDX_W-1:0];
                o_lnk_raddr = r_ihead[IDX_W-1:0];
                o_pst_raddr = (i_in_req.opcode == OP_WRITE_PAIR) ? i_in_req.cell_index
                                                                 : in_car.idx;
                o_ist_raddr = in_car.idx;
                o_loc_raddr = lcnt_dec[SP_W-1:0];
                if (i_in_valid) begin
                    n_cell   = i_in_req.cell_index;
                    n_car    = in_car;
                    n_cdr    = in_cdr;
                    n_ref    = in_car;
                    n_status = STS_OK;
                    n_res    = '0;
                    n_state  = S_RESP;
                    case (i_in_req.opcode)
                        OP_ALLOC_PAIR: begin
                            if (r_phead[HEAD_W-1]) begin
                                n_status = STS_EMPTY;
                            end else begin
                                n_state = S_AP_WR;
                            end
                        end
                        OP_ALLOC_INT: begin
                            if (r_ihead[HEAD_W-1]) begin
                                n_status = STS_EMPTY;
                            end else begin
                                n_state = S_AI_WR;
                            end
                        end
                        OP_WRITE_PAIR: begin
                            n_state = S_WP_WR;
                        end
                        OP_SET_ROOT: begin
                            n_roots[i_in_req.root_slot] = in_car;
                        end
                        OP_PUSH_LOCAL: begin
                            if (in_car.kind == KIND_NULL) begin
                                n_status = STS_EMPTY;
                            end else begin
                                n_state = S_PU_WR;
                            end
                        end
                        OP_POP_LOCAL: begin
                            if (r_lcnt == '0) begin
                                n_status = STS_EMPTY;
                            end else begin
                                n_lcnt  = lcnt_dec;
                                n_state = S_PO_ST;
                            end
                        end
                        OP_COLLECT: begin
                            n_tcnt  = '0;
                            n_idx   = '0;
                            n_abort = 1'b0;
                            n_state = S_CR_RD;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_AP_WR: begin
                o_pst_we    = 1'b1;
                o_pst_waddr = r_phead[IDX_W-1:0];
                o_pst_wdata = CS_UNMARKED;
                o_car_we    = 1'b1;
                o_car_waddr = r_phead[IDX_W-1:0];
                o_cdr_we    = 1'b1;
                o_cdr_waddr = r_phead[IDX_W-1:0];
                n_res       = t_ref'({KIND_PAIR, r_phead[IDX_W-1:0]});
                n_phead     = (i_cdr_rdata.kind == KIND_PAIR) ? {1'b0, i_cdr_rdata.idx}
                                                              : HEAD_END;
                n_state     = S_RESP;
            end
            S_AI_WR: begin
                o_ist_we    = 1'b1;
                o_ist_waddr = r_ihead[IDX_W-1:0];
                o_ist_wdata = CS_UNMARKED;
                n_res       = t_ref'({KIND_INT, r_ihead[IDX_W-1:0]});
                n_ihead     = i_lnk_rdata[HEAD_W-1] ? HEAD_END : i_lnk_rdata;
                n_state     = S_RESP;
            end
            S_WP_WR: begin
                if (i_pst_rdata != CS_FREE) begin
                    o_car_we    = 1'b1;
                    o_car_waddr = r_cell;
                    o_car_wdata = r_car;
                    o_cdr_we    = 1'b1;
                    o_cdr_waddr = r_cell;
                    o_cdr_wdata = r_cdr;
                end
                n_state = S_RESP;
            end
            S_PU_WR: begin
                if (cur_st == CS_FREE) begin
                    n_status = STS_EMPTY;
                end else if (r_lcnt[CNT_W-1]) begin
                    n_status = STS_LOCAL_OVF;
                end else begin
                    st_we    = 1'b1;
                    o_loc_we = 1'b1;
                    n_lcnt   = r_lcnt + CNT_W'(1);
                end
                n_state = S_RESP;
            end
            S_PO_ST: begin
                n_res       = i_loc_rdata;
                n_ref       = i_loc_rdata;
                o_pst_raddr = i_loc_rdata.idx;
                o_ist_raddr = i_loc_rdata.idx;
                n_state     = S_PO_WR;
            end
            S_PO_WR: begin
                if (cur_st != CS_FREE) begin
                    st_we  = 1'b1;
                    st_val = CS_UNMARKED;
                end
                n_state = S_RESP;
            end
            S_CR_RD: begin
                n_ref       = root_cur;
                o_pst_raddr = root_cur.idx;
                o_ist_raddr = root_cur.idx;
                n_state     = S_CR_EV;
            end
            S_CR_EV: begin
                push_go = (cur_st != CS_FREE);
                if (push_go && push_ovf) begin
                    n_abort = 1'b1;
                    n_idx   = '0;
                    n_state = S_SW_RD;
                end else if (r_idx[SLOT_W-1:0] == ROOT_LAST) begin
                    n_idx   = '0;
                    n_state = (r_lcnt == '0) ? S_TR_POP : S_CL_RD;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = S_CR_RD;
                end
            end
            S_CL_RD: begin
                n_state = S_CL_ST;
            end
            S_CL_ST: begin
                n_ref       = i_loc_rdata;
                o_pst_raddr = i_loc_rdata.idx;
                o_ist_raddr = i_loc_rdata.idx;
                n_state     = S_CL_EV;
            end
            S_CL_EV: begin
                push_go = (cur_st != CS_FREE);
                if (push_go && push_ovf) begin
                    n_abort = 1'b1;
                    n_idx   = '0;
                    n_state = S_SW_RD;
                end else if (idx_inc == r_lcnt) begin
                    n_idx   = '0;
                    n_state = S_TR_POP;
                end else begin
                    n_idx   = idx_inc[IDX_W-1:0];
                    n_state = S_CL_RD;
                end
            end
            S_TR_POP: begin
                if (r_tcnt == '0) begin
                    n_idx   = '0;
                    n_state = S_SW_RD;
                end else begin
                    n_tcnt  = tcnt_dec;
                    n_state = S_TR_RD;
                end
            end
            S_TR_RD: begin
                o_car_raddr = i_trc_rdata.idx;
                o_cdr_raddr = i_trc_rdata.idx;
                n_state     = (i_trc_rdata.kind == KIND_PAIR) ? S_TR_KID : S_TR_POP;
            end
            S_TR_KID: begin
                n_ref       = i_cdr_rdata;
                n_kid       = i_car_rdata;
                n_second    = 1'b0;
                o_pst_raddr = i_cdr_rdata.idx;
                o_ist_raddr = i_cdr_rdata.idx;
                n_state     = S_TR_EV;
            end
            S_TR_ST: begin
                o_pst_raddr = r_ref.idx;
                o_ist_raddr = r_ref.idx;
                n_second    = 1'b1;
                n_state     = S_TR_EV;
            end
            S_TR_EV: begin
                push_go = (cur_st == CS_UNMARKED);
                if (push_go && push_ovf) begin
                    n_abort = 1'b1;
                    n_idx   = '0;
                    n_state = S_SW_RD;
                end else if (!r_second) begin
                    n_ref   = r_kid;
                    n_state = S_TR_ST;
                end else begin
                    n_state = S_TR_POP;
                end
            end
            S_SW_RD: begin
                n_state = S_SW_WR;
            end
            S_SW_WR: begin
                if (i_ist_rdata == CS_MARKED) begin
                    o_ist_we    = 1'b1;
                    o_ist_wdata = CS_UNMARKED;
                end else if (i_ist_rdata == CS_UNMARKED && !r_abort) begin
                    o_ist_we    = 1'b1;
                    o_lnk_we    = 1'b1;
                    o_lnk_wdata = r_ihead;
                    n_ihead     = {1'b0, r_idx};
                end
                if (i_pst_rdata == CS_MARKED) begin
                    o_pst_we    = 1'b1;
                    o_pst_wdata = CS_UNMARKED;
                end else if (i_pst_rdata == CS_UNMARKED && !r_abort) begin
                    o_pst_we    = 1'b1;
                    o_car_we    = 1'b1;
                    o_cdr_we    = 1'b1;
                    o_cdr_wdata = r_phead[HEAD_W-1] ? '0
                                                    : t_ref'({KIND_PAIR, r_phead[IDX_W-1:0]});
                    n_phead     = {1'b0, r_idx};
                end
                if (r_idx == CELL_LAST) begin
                    n_tcnt   = '0;
                    n_status = r_abort ? STS_TRACE_OVF : STS_OK;
                    n_state  = S_RESP;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = S_SW_RD;
                end
            end
            S_RESP: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out       = '{status: r_status, ref_kind: r_res.kind,
                                    ref_index: r_res.idx};
                    n_state     = S_IDLE;
                end
            end
        endcase

        if (push_go && !push_ovf) begin
            st_we    = 1'b1;
            o_trc_we = 1'b1;
            n_tcnt   = r_tcnt + CNT_W'(1);
        end
        if (st_we) begin
            o_pst_we    = (r_ref.kind == KIND_PAIR);
            o_pst_waddr = r_ref.idx;
            o_pst_wdata = st_val;
            o_ist_we    = (r_ref.kind == KIND_INT);
            o_ist_waddr = r_ref.idx;
            o_ist_wdata = st_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_phead     <= HEAD_W'(PAIR_CELLS - 1);
            r_ihead     <= HEAD_W'(INT_CELLS - 1);
            r_lcnt      <= '0;
            r_tcnt      <= '0;
            r_roots     <= '{default: '0};
            r_second    <= 1'b0;
            r_abort     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_phead     <= n_phead;
            r_ihead     <= n_ihead;
            r_lcnt      <= n_lcnt;
            r_tcnt      <= n_tcnt;
            r_roots     <= n_roots;
            r_second    <= n_second;
            r_abort     <= n_abort;
            r_out_valid <= n_out_valid;
        end
        r_cell   <= n_cell;
        r_car    <= n_car;
        r_cdr    <= n_cdr;
        r_ref    <= n_ref;
        r_kid    <= n_kid;
        r_res    <= n_res;
        r_status <= n_status;
        r_out    <= n_out;
    end

endmodule

// ===== sv/mark_sweep_cell_collector_core.sv =====
// A collection first evaluates each root, then each live local, then traces the stack of
// reached cells, following both children of each traced pair, and last sweeps each cell
// index of the two 512-cell pools, with both pools handled at the same index.
// One request at a time; the single state-memory read per step sets the pace.
// After reset a clearing pass over all 512 cells initializes the cell memories; requests stall.
// Top level: cell memories and the collector sequencer; depends on msc_pkg, msc_ram, msc_seq.
module mark_sweep_cell_collector_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  msc_pkg::t_in_req  i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output msc_pkg::t_out_req o_out_req
);
    import msc_pkg::*;

    logic       car_we, cdr_we, pst_we, ist_we, lnk_we, loc_we, trc_we;
    logic [8:0] car_waddr, car_raddr, cdr_waddr, cdr_raddr;
    logic [8:0] pst_waddr, pst_raddr, ist_waddr, ist_raddr, lnk_waddr, lnk_raddr;
    logic [7:0] loc_waddr, loc_raddr, trc_waddr, trc_raddr;
    t_ref       car_wdata, car_rdata, cdr_wdata, cdr_rdata;
    t_ref       loc_wdata, loc_rdata, trc_wdata, trc_rdata;
    logic [1:0] pst_wdata, pst_rdata, ist_wdata, ist_rdata;
    logic [9:0] lnk_wdata, lnk_rdata;

    msc_ram #(.W(REF_W), .D(PAIR_CELLS)) u_car (
        .i_clk(i_clk), .i_we(car_we), .i_waddr(car_waddr), .i_wdata(car_wdata),
        .i_raddr(car_raddr), .o_rdata(car_rdata)
    );
    msc_ram #(.W(REF_W), .D(PAIR_CELLS)) u_cdr (
        .i_clk(i_clk), .i_we(cdr_we), .i_waddr(cdr_waddr), .i_wdata(cdr_wdata),
        .i_raddr(cdr_raddr), .o_rdata(cdr_rdata)
    );
    msc_ram #(.W(CST_W), .D(PAIR_CELLS)) u_pst (
        .i_clk(i_clk), .i_we(pst_we), .i_waddr(pst_waddr), .i_wdata(pst_wdata),
        .i_raddr(pst_raddr), .o_rdata(pst_rdata)
    );
    msc_ram #(.W(CST_W), .D(INT_CELLS)) u_ist (
        .i_clk(i_clk), .i_we(ist_we), .i_waddr(ist_waddr), .i_wdata(ist_wdata),
        .i_raddr(ist_raddr), .o_rdata(ist_rdata)
    );
    msc_ram #(.W(HEAD_W), .D(INT_CELLS)) u_lnk (
        .i_clk(i_clk), .i_we(lnk_we), .i_waddr(lnk_waddr), .i_wdata(lnk_wdata),
        .i_raddr(lnk_raddr), .o_rdata(lnk_rdata)
    );
    msc_ram #(.W(REF_W), .D(STACK_DEPTH)) u_loc (
        .i_clk(i_clk), .i_we(loc_we), .i_waddr(loc_waddr), .i_wdata(loc_wdata),
        .i_raddr(loc_raddr), .o_rdata(loc_rdata)
    );
    msc_ram #(.W(REF_W), .D(STACK_DEPTH)) u_trc (
        .i_clk(i_clk), .i_we(trc_we), .i_waddr(trc_waddr), .i_wdata(trc_wdata),
        .i_raddr(trc_raddr), .o_rdata(trc_rdata)
    );

    msc_seq u_seq (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_req(i_in_req),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_req(o_out_req),
        .o_car_we(car_we), .o_car_waddr(car_waddr), .o_car_wdata(car_wdata),
        .o_car_raddr(car_raddr), .i_car_rdata(car_rdata),
        .o_cdr_we(cdr_we), .o_cdr_waddr(cdr_waddr), .o_cdr_wdata(cdr_wdata),
        .o_cdr_raddr(cdr_raddr), .i_cdr_rdata(cdr_rdata),
        .o_pst_we(pst_we), .o_pst_waddr(pst_waddr), .o_pst_wdata(pst_wdata),
        .o_pst_raddr(pst_raddr), .i_pst_rdata(pst_rdata),
        .o_ist_we(ist_we), .o_ist_waddr(ist_waddr), .o_ist_wdata(ist_wdata),
        .o_ist_raddr(ist_raddr), .i_ist_rdata(ist_rdata),
        .o_lnk_we(lnk_we), .o_lnk_waddr(lnk_waddr), .o_lnk_wdata(lnk_wdata),
        .o_lnk_raddr(lnk_raddr), .i_lnk_rdata(lnk_rdata),
        .o_loc_we(loc_we), .o_loc_waddr(loc_waddr), .o_loc_wdata(loc_wdata),
        .o_loc_raddr(loc_raddr), .i_loc_rdata(loc_rdata),
        .o_trc_we(trc_we), .o_trc_waddr(trc_waddr), .o_trc_wdata(trc_wdata),
        .o_trc_raddr(trc_raddr), .i_trc_rdata(trc_rdata)
    );

    // A request is worked on alone, so the block stalls right after taking one.
    a_stall_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted while another is in progress");

    // A failed request never returns a cell reference.
    a_fail_no_ref: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_req.status != STS_OK) |-> (o_out_req.ref_kind == KIND_NULL))
        else $error("reference returned with a failing status");

    // A result reference is null, a pair or an int, never the unused kind.
    a_ref_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_req.ref_kind != 2'd3))
        else $error("invalid reference kind on result");

endmodule
